// File: rtl/gsm_septet_packer_unpacker_top_assert.svh
// Assertion macros used by the checker file.
`ifndef GSM_SEPTET_PACKER_UNPACKER_TOP_ASSERT_SVH
`define GSM_SEPTET_PACKER_UNPACKER_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define GSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define GSP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/gsp_pkg.sv
package gsp_pkg;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned SEPT_W   = 7;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned ACC_W    = 14;
	localparam int unsigned HELD_W   = 4;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [SEPT_W-1:0] SEPTET_MASK = 7'h7f;

	// Word index of the mode register.
	localparam logic REG_UNPACK_MODE = 1'b0;

	// Depth of the result queue; must be at least two.
	localparam int unsigned OUT_DEPTH_DEF = 4;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              last;
	} res_t;

endpackage

// File: rtl/gsp_in_if.sv
interface gsp_in_if;
	logic                         valid;
	logic                         ready;
	logic [gsp_pkg::DATA_W-1:0]   in_data;
	logic                         in_last;
	logic [gsp_pkg::CNT_W-1:0]    septet_total;

	modport source (output valid, in_data, in_last, septet_total, input ready);
	modport sink   (input valid, in_data, in_last, septet_total, output ready);
endinterface

// File: rtl/gsp_out_if.sv
interface gsp_out_if;
	logic                         valid;
	logic                         ready;
	logic [gsp_pkg::DATA_W-1:0]   out_data;
	logic                         out_last;

	modport source (output valid, out_data, out_last, input ready);
	modport sink   (input valid, out_data, out_last, output ready);
endinterface

// File: rtl/gsm_septet_packer_unpacker_top.sv
// GSM 7-bit septet packer/unpacker (SMS user data, LSB first). Register 0 (unpack_mode)
// selects packing septets into octets (0) or unpacking octets into septets (1); writing it
// restarts the message. Each accepted transaction updates a 14-bit bit accumulator and
// pushes zero, one or two results into an OUT_DEPTH-entry result queue. An input
// transaction is accepted in any cycle in which the queue has room for two results, so
// inputs can arrive every cycle; the output side drains one result per cycle while ready is
// high, which sets the sustained rate: one item per cycle when packing, while unpacking takes
// octets more slowly than septets leave, since eight septets come out of seven octets. Packing with
// in_last set always yields at least one octet, zero padded; unpacking stops at
// septet_total characters and drops the pad bits.
module gsm_septet_packer_unpacker_top #(
	parameter int unsigned OUT_DEPTH = gsp_pkg::OUT_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	gsp_in_if.sink                        in_ch,
	gsp_out_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gsp_pkg::PADDR_W-1:0]   paddr,
	input  logic [gsp_pkg::PDATA_W-1:0]   pwdata,
	output logic [gsp_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int unsigned PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(OUT_DEPTH + 1);
	localparam int unsigned ACC_W = gsp_pkg::ACC_W;
	localparam int unsigned HELD_W = gsp_pkg::HELD_W;
	localparam int unsigned CNT_W = gsp_pkg::CNT_W;
	localparam int unsigned DATA_W = gsp_pkg::DATA_W;
	localparam int unsigned SEPT_W = gsp_pkg::SEPT_W;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		nxt = (ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : ptr + 1'b1;
		return nxt;
	endfunction

	// message state
	logic                 mode_q;
	logic [ACC_W-1:0]     acc_q, acc_n;
	logic [HELD_W-1:0]    held_q, held_n;
	logic [CNT_W-1:0]     emitted_q, emitted_n;

	// result queue
	gsp_pkg::res_t        mem_q [OUT_DEPTH];
	logic [PTR_W-1:0]     rd_q, wr_q, wr_p1, wr_p2;
	logic [QCNT_W-1:0]    qcnt_q;

	// per-item work
	logic [ACC_W-1:0]     p_acc, u_acc;
	logic [HELD_W-1:0]    p_sum, u_sum;
	logic [CNT_W-1:0]     cnt1, cnt2;
	logic [1:0]           res_n;
	gsp_pkg::res_t        res0, res1;

	logic                 in_fire, out_fire, cfg_wr;

	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == gsp_pkg::REG_UNPACK_MODE) ?
	                  {{(gsp_pkg::PDATA_W-1){1'b0}}, mode_q} : '0;

	assign in_ch.ready = (qcnt_q <= QCNT_W'(OUT_DEPTH - 2));
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_ch.valid = (qcnt_q != '0);
	assign out_fire    = out_ch.valid && out_ch.ready;
	assign out_ch.out_data = mem_q[rd_q].data;
	assign out_ch.out_last = mem_q[rd_q].last;

	assign p_acc = acc_q | (ACC_W'(in_ch.in_data[SEPT_W-1:0] & gsp_pkg::SEPTET_MASK) << held_q);
	assign p_sum = held_q + HELD_W'(7);
	assign u_acc = acc_q | (ACC_W'(in_ch.in_data) << held_q);
	assign u_sum = held_q + HELD_W'(8);
	assign cnt1  = emitted_q + 1'b1;
	assign cnt2  = emitted_q + CNT_W'(2);

	always_comb begin
		acc_n     = acc_q;
		held_n    = held_q;
		emitted_n = emitted_q;
		res_n     = 2'd0;
		res0      = '0;
		res1      = '0;
		if (!mode_q) begin
			if (p_sum >= HELD_W'(8)) begin
				res0   = '{data: p_acc[DATA_W-1:0], last: 1'b0};
				res_n  = 2'd1;
				acc_n  = p_acc >> DATA_W;
				held_n = p_sum - HELD_W'(8);
			end else begin
				acc_n  = p_acc;
				held_n = p_sum;
			end
			if (in_ch.in_last) begin
				// flush leftover bits as a zero-padded octet
				if (held_n != '0) begin
					if (res_n == 2'd1) begin
						res1  = '{data: acc_n[DATA_W-1:0], last: 1'b1};
						res_n = 2'd2;
					end else begin
						res0  = '{data: acc_n[DATA_W-1:0], last: 1'b1};
						res_n = 2'd1;
					end
				end else begin
					res0.last = 1'b1;
				end
				acc_n     = '0;
				held_n    = '0;
				emitted_n = '0;
			end
		end else begin
			if (emitted_q < in_ch.septet_total) begin
				res0  = '{data: {1'b0, u_acc[SEPT_W-1:0]}, last: (cnt1 == in_ch.septet_total)};
				res_n = 2'd1;
				if ((u_sum >= HELD_W'(14)) && (cnt1 < in_ch.septet_total)) begin
					res1 = '{data: {1'b0, u_acc[2*SEPT_W-1:SEPT_W]},
					         last: (cnt2 == in_ch.septet_total)};
					res_n     = 2'd2;
					acc_n     = '0;
					held_n    = u_sum - HELD_W'(14);
					emitted_n = cnt2;
				end else begin
					acc_n     = u_acc >> SEPT_W;
					held_n    = u_sum - HELD_W'(7);
					emitted_n = cnt1;
				end
				// count reached: drop pad bits
				if (emitted_n >= in_ch.septet_total) begin
					acc_n  = '0;
					held_n = '0;
				end
			end
			if (in_ch.in_last) begin
				if (res_n == 2'd1) begin
					res0.last = 1'b1;
				end
				if (res_n == 2'd2) begin
					res1.last = 1'b1;
				end
				acc_n     = '0;
				held_n    = '0;
				emitted_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			acc_q     <= '0;
			held_q    <= '0;
			emitted_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == gsp_pkg::REG_UNPACK_MODE) begin
				mode_q    <= pwdata[0];
				acc_q     <= '0;
				held_q    <= '0;
				emitted_q <= '0;
			end
		end else if (in_fire) begin
			acc_q     <= acc_n;
			held_q    <= held_n;
			emitted_q <= emitted_n;
		end
	end

	assign wr_p1 = ptr_inc(wr_q);
	assign wr_p2 = ptr_inc(wr_p1);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (res_n != 2'd0) begin
				mem_q[wr_q] <= res0;
			end
			if (res_n == 2'd2) begin
				mem_q[wr_p1] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			wr_q   <= '0;
			qcnt_q <= '0;
		end else begin
			if (out_fire) begin
				rd_q <= ptr_inc(rd_q);
			end
			if (in_fire) begin
				case (res_n)
					2'd1:    wr_q <= wr_p1;
					2'd2:    wr_q <= wr_p2;
					default: wr_q <= wr_q;
				endcase
			end
			qcnt_q <= qcnt_q + (in_fire ? QCNT_W'(res_n) : '0) - QCNT_W'(out_fire);
		end
	end

endmodule

// File: rtl/gsp_checker.sv
`include "gsm_septet_packer_unpacker_top_assert.svh"

module gsp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [gsp_pkg::DATA_W-1:0]  out_data,
	input logic                        out_last
);

	// a result only appears in the cycle after an input transaction
	`GSP_ASSERT(a_out_after_in, $rose(out_valid) |-> $past(in_valid && in_ready), "result without input transaction")

	// an empty result queue always has room for input
	`GSP_ASSERT_ALWAYS(a_ready_when_empty, !out_valid |-> in_ready, "input stalled while output idle")

	`GSP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output valid dropped while stalled")

	`GSP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data) && $stable(out_last), "output payload changed while stalled")

endmodule

bind gsm_septet_packer_unpacker_top gsp_checker u_gsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.out_data),
	.out_last  (out_ch.out_last)
);
